>>> rtl/bsc_pkg.sv
// Shared constants and types for the multi-stream ordered bit scanner.
package bsc_pkg;

    localparam int STREAMS     = 4;
    localparam int WORD_BITS   = 16;

    localparam int IN_FIELDS   = 4;
    localparam int IN_FIELD_W  = 16;
    localparam int IN_DATA_W   = IN_FIELDS * IN_FIELD_W;
    localparam int POS_W       = 32;
    localparam int STREAM_W    = 2;

    localparam int SCAN_BITS   = STREAMS * WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);

    typedef struct packed {
        logic [SCAN_BITS-1:0] rest;
        logic [BIT_W-1:0]     bit_idx;
        logic [STREAM_W-1:0]  stream_idx;
    } bsc_find_t;

endpackage

>>> rtl/bsc_find_first.sv
// Shared find-first unit: picks the lowest pending bit of the interleaved scan vector.
module bsc_find_first (
    input  logic [bsc_pkg::SCAN_BITS-1:0] scan_vec,
    output bsc_pkg::bsc_find_t            find
);
    import bsc_pkg::*;

    logic [SCAN_BITS-1:0] lowest;

    // Isolate the lowest set bit; bit j stands for word bit j/STREAMS of stream j%STREAMS.
    assign lowest = scan_vec & (~scan_vec + SCAN_BITS'(1));

    always_comb begin
        find.rest       = scan_vec ^ lowest;
        find.bit_idx    = '0;
        find.stream_idx = '0;
        for (int j = 0; j < SCAN_BITS; j++) begin
            if (lowest[j]) begin
                find.bit_idx    = find.bit_idx | BIT_W'(j / STREAMS);
                find.stream_idx = find.stream_idx | STREAM_W'(j % STREAMS);
            end
        end
    end

endmodule

>>> rtl/multi_stream_ordered_bit_scanner.sv
// Top level of the multi-stream ordered bit scanner: sequencer, position base and output register.
//
// Usage:
//   s_ channel: one transfer carries one word of marker bits for each stream,
//   stream k in s_tdata[16k +: 16]. m_ channel: one transfer per set bit, with
//   the absolute position in m_tdata, the stream index in m_tuser and m_tlast
//   on the final result of each word. Results come out in ascending position,
//   lower stream first at equal positions.
//   cfg_wr_en/cfg_wr_data write start_position; write it only while idle.
// Timing:
//   A word is taken into a scan register; a find-first unit then retires one
//   set bit per cycle into the output register, except while a result waits on
//   m_tready; the first result passes through the scan register first. A word
//   with set bits keeps s_tready low until its last bit is retired, paced by
//   the single find-first unit; a word with no set bits gives no result and
//   the next transfer can follow in the next cycle. s_tready is low while
//   bits of a word remain to be retired.
// Reset and stall:
//   aresetn low clears the word counter, start_position and all pending work.
//   While m_tready is low with a result held, the output register holds and the scan stops.
module multi_stream_ordered_bit_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bsc_pkg::POS_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: stream0_bits, stream1_bits, stream2_bits, stream3_bits
    input  logic [bsc_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: position
    output logic [bsc_pkg::POS_W-1:0]     m_tdata,
    // m_tuser: stream_index
    output logic [bsc_pkg::STREAM_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import bsc_pkg::*;

    logic [SCAN_BITS-1:0] scan_reg, scan_next;
    logic                 busy_reg, busy_next;
    logic [POS_W-1:0]     start_reg, start_next;
    logic [POS_W-1:0]     offset_reg, offset_next;
    logic [POS_W-1:0]     base_reg, base_next;
    logic                 m_valid_reg, m_valid_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [STREAM_W-1:0]  sidx_reg, sidx_next;
    logic                 last_reg, last_next;

    logic [SCAN_BITS-1:0] load_vec;
    logic                 in_xfer;
    logic                 step;
    bsc_find_t            find;

    bsc_find_first u_find (
        .scan_vec (scan_reg),
        .find     (find)
    );

    // Interleave streams so bit order matches position order, lower stream first.
    always_comb begin
        load_vec = '0;
        for (int s = 0; s < STREAMS; s++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                load_vec[i*STREAMS + s] = s_tdata[s*IN_FIELD_W + i];
            end
        end
    end

    assign s_tready = !busy_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign step     = busy_reg && (!m_valid_reg || m_tready);

    always_comb begin
        scan_next    = scan_reg;
        busy_next    = busy_reg;
        start_next   = start_reg;
        offset_next  = offset_reg;
        base_next    = base_reg;
        m_valid_next = m_valid_reg;
        pos_next     = pos_reg;
        sidx_next    = sidx_reg;
        last_next    = last_reg;

        if (cfg_wr_en) begin
            start_next = cfg_wr_data;
        end

        if (in_xfer) begin
            scan_next   = load_vec;
            busy_next   = |load_vec;
            base_next   = start_reg + offset_reg;
            offset_next = offset_reg + POS_W'(WORD_BITS);
        end

        if (step) begin
            scan_next    = find.rest;
            busy_next    = |find.rest;
            m_valid_next = 1'b1;
            pos_next     = base_reg + POS_W'(find.bit_idx);
            sidx_next    = find.stream_idx;
            last_next    = ~|find.rest;
        end else if (m_tready) begin
            // drop the result once transferred
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg    <= '0;
            busy_reg    <= 1'b0;
            start_reg   <= '0;
            offset_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            scan_reg    <= scan_next;
            busy_reg    <= busy_next;
            start_reg   <= start_next;
            offset_reg  <= offset_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        pos_reg  <= pos_next;
        sidx_reg <= sidx_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pos_reg;
    assign m_tuser  = sidx_reg;
    assign m_tlast  = last_reg;

    // A word with any set bit keeps the scanner busy.
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && |load_vec) |=> busy_reg)
        else $error("scanner not busy after nonempty word");

    // An idle scanner has no pending bits left.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (scan_reg == '0))
        else $error("pending bits while scanner idle");

    // A result that is not the last of its word leaves more work pending.
    a_more_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !last_reg) |-> busy_reg)
        else $error("non-last result without pending bits");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the multi-stream ordered bit scanner.
module testbench;
    import bsc_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [STREAM_W-1:0] stream;
        logic                last;
    } scan_hit_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [POS_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [POS_W-1:0]     m_tdata;
    logic [STREAM_W-1:0]  m_tuser;
    logic                 m_tlast;

    // predictor state and the hits still owed by the block
    logic [POS_W-1:0] base_offset;
    logic [POS_W-1:0] words_seen;
    scan_hit_t        pending_hits[$];
    scan_hit_t        due_hit;
    int               errors;
    logic             feed_idle;
    logic             sink_idle;

    multi_stream_ordered_bit_scanner DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("[multi_stream_ordered_bit_scanner] ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input logic enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_streams(input logic [15:0] f0,
            input logic [15:0] f1, input logic [15:0] f2, input logic [15:0] f3);
        return {f3, f2, f1, f0};
    endfunction

    // expand one word into its hits: bit index major, stream index minor
    function automatic void predict_word(input logic [IN_DATA_W-1:0] w);
        logic [POS_W-1:0]     base;
        logic [WORD_BITS-1:0] marks[STREAMS];
        int                   total;
        int                   n;
        scan_hit_t            hit;
        total = 0;
        n = 0;
        for (int s = 0; s < STREAMS; s++) begin
            marks[s] = w[s*IN_FIELD_W +: WORD_BITS];
            total += $countones(marks[s]);
        end
        base = base_offset + words_seen * POS_W'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++) begin
            for (int s = 0; s < STREAMS; s++) begin
                if (marks[s][i]) begin
                    n++;
                    hit.position = base + POS_W'(i);
                    hit.stream   = STREAM_W'(s);
                    hit.last     = (n == total);
                    pending_hits.push_back(hit);
                end
            end
        end
        words_seen = words_seen + 1'b1;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_word();
        logic [IN_DATA_W-1:0] w;
        int                   kind;
        kind = $urandom_range(0, 99);
        for (int s = 0; s < IN_FIELDS; s++) begin
            if (kind < 10)
                w[s*IN_FIELD_W +: IN_FIELD_W] = '0;
            else if (kind < 15)
                w[s*IN_FIELD_W +: IN_FIELD_W] = IN_FIELD_W'($urandom | $urandom);
            else if (kind < 75)
                w[s*IN_FIELD_W +: IN_FIELD_W] = IN_FIELD_W'($urandom & $urandom & $urandom);
            else
                w[s*IN_FIELD_W +: IN_FIELD_W] = IN_FIELD_W'($urandom);
        end
        return w;
    endfunction

    // called at a falling edge; leaves tvalid high when no gap follows
    task automatic send_word(input logic [IN_DATA_W-1:0] w);
        int gap;
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_word(w);
        @(negedge aclk);
        gap = pick_gap(feed_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(negedge aclk);
    endtask

    // empty words leave no trace in the queue, so let the scanner settle too
    task automatic write_start(input logic [POS_W-1:0] value);
        wait_drained();
        repeat (6) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        base_offset = value;
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) send_word(random_word());
    endtask

    task automatic test_directed_edges();
        send_word(pack_streams(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_word(pack_streams(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(pack_streams(16'h0001, 16'h0000, 16'h0000, 16'h0000));
        send_word(pack_streams(16'h0000, 16'h0000, 16'h0000, 16'h8000));
        send_word(pack_streams(16'h0020, 16'h0020, 16'h0020, 16'h0020));
        send_word(pack_streams(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
        send_word(pack_streams(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_word(pack_streams(16'h8000, 16'h4000, 16'h0002, 16'h0001));
        send_word(pack_streams(16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    endtask

    task automatic test_position_wrap();
        // next word starts eight positions below the wrap point
        write_start(POS_W'(0) - words_seen * POS_W'(WORD_BITS) - POS_W'(8));
        send_word(pack_streams(16'hFFFF, 16'h0000, 16'h8001, 16'h0180));
        send_word(pack_streams(16'h0101, 16'h0000, 16'h0000, 16'h0000));
        send_word(pack_streams(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        write_start(32'hFFFF_FFFF);
        send_word(pack_streams(16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF));
        send_word(pack_streams(16'h0000, 16'h8000, 16'h0000, 16'h0000));
        send_word(pack_streams(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
    endtask

    task automatic test_config_sweep();
        write_start(32'h0000_0000);
        send_random(60);
        // back to back in both directions
        feed_idle = 1'b0;
        sink_idle = 1'b0;
        write_start(POS_W'($urandom));
        send_random(60);
        feed_idle = 1'b1;
        sink_idle = 1'b1;
        write_start(32'h8000_0000);
        send_random(60);
        write_start(32'hFFFF_FFF0);
        send_random(60);
    endtask

    task automatic test_drain_pause();
        send_random(20);
        // hold the sender until every hit so far has been delivered
        wait_drained();
        send_random(20);
    endtask

    task automatic test_random_stream();
        write_start(POS_W'($urandom));
        send_random(80);
        sink_idle = 1'b0;
        send_random(40);
        sink_idle = 1'b1;
        send_random(45);
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (10) @(negedge aclk);
        if (pending_hits.size() != 0) begin
            errors++;
            $display("%0t: %0d hits never delivered, next position %h stream %0d",
                     $time, pending_hits.size(), pending_hits[0].position,
                     pending_hits[0].stream);
        end
        if (errors == 0)
            $display("[multi_stream_ordered_bit_scanner] OK");
        else
            $display("[multi_stream_ordered_bit_scanner] ERROR");
        $finish;
    endtask

    // receiver side stalls
    initial begin : sink_drive
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 99) < 25) begin
                hold = pick_gap(1'b1);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer: position %h stream %0d last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                due_hit = pending_hits.pop_front();
                if (m_tdata !== due_hit.position) begin
                    errors++;
                    $display("%0t: position expected %h actual %h",
                             $time, due_hit.position, m_tdata);
                end
                if (m_tuser !== due_hit.stream) begin
                    errors++;
                    $display("%0t: stream expected %0d actual %0d",
                             $time, due_hit.stream, m_tuser);
                end
                if (m_tlast !== due_hit.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, due_hit.last, m_tlast);
                end
            end
        end
    end

    initial begin
        errors      = 0;
        base_offset = '0;
        words_seen  = '0;
        feed_idle   = 1'b1;
        sink_idle   = 1'b1;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_edges();
        test_position_wrap();
        test_config_sweep();
        test_drain_pause();
        test_random_stream();
        finish_run();
    end

endmodule
